>>> sv/ascii_integer_parser_defines.svh
// Assertion macros shared by the ASCII integer parser modules.
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define AIP_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define AIP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/aip_pkg.sv
// Types, constants and character codes of the ASCII integer parser.
package aip_pkg;

   localparam int CH_W    = 8;
   localparam int BASE_W  = 6;
   localparam int VALUE_W = 32;
   localparam int OFF_W   = 10;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam int COUNT_LIMIT_DEF = 1023;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_BASE_SELECT = 1'b0;

   // Base codes.
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

   // Character codes.
   localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CH_W-1:0] CH_NL      = 8'h0A;
   localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;

   // Value of the letter 'a' as a digit.
   localparam logic [CH_W-1:0] ALPHA_DIGIT_OFS = 8'd10;

   typedef struct packed {
      logic              is_space;
      logic              is_sign;
      logic              is_minus;
      logic              is_zero;
      logic              is_x;
      logic              is_alnum;
      logic [BASE_W-1:0] digit;
   } char_class_type;

   typedef struct packed {
      char_class_type    cls;
      logic [BASE_W-1:0] base_sel;
   } cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [OFF_W-1:0]   end_offset;
   } result_type;

endpackage

>>> sv/aip_fifo.sv
// Small first-word-fall-through queue, used between the parser stages and as the result queue.
`include "ascii_integer_parser_defines.svh"

module aip_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   `AIP_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "queue count above depth")
   `AIP_ASSERT_IMPL(a_ptr_match, full || empty, wr_ptr_ff == rd_ptr_ff, "queue pointers disagree")
   `AIP_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule

>>> sv/aip_front.sv
// Front stage: classifies each incoming character and queues it with the base setting.
module aip_front (
   input  logic                        req_push,
   input  logic [aip_pkg::CH_W-1:0]    req_ch,
   input  logic [aip_pkg::BASE_W-1:0]  base_sel,
   input  logic                        q_full,
   output logic                        q_push,
   output aip_pkg::cmd_type            cmd
);

   aip_pkg::char_class_type cls;

   always_comb begin
      cls          = '0;
      cls.is_space = (req_ch == aip_pkg::CH_SPACE) || (req_ch == aip_pkg::CH_TAB) ||
                     (req_ch == aip_pkg::CH_NL);
      cls.is_sign  = (req_ch == aip_pkg::CH_PLUS) || (req_ch == aip_pkg::CH_MINUS);
      cls.is_minus = (req_ch == aip_pkg::CH_MINUS);
      cls.is_zero  = (req_ch == aip_pkg::CH_ZERO);
      cls.is_x     = (req_ch == aip_pkg::CH_LOWER_X) || (req_ch == aip_pkg::CH_UPPER_X);
      if (req_ch inside {[aip_pkg::CH_ZERO:aip_pkg::CH_NINE]}) begin
         cls.is_alnum = 1'b1;
         cls.digit    = aip_pkg::BASE_W'(req_ch - aip_pkg::CH_ZERO);
      end else if (req_ch inside {[aip_pkg::CH_LOWER_A:aip_pkg::CH_LOWER_Z]}) begin
         cls.is_alnum = 1'b1;
         cls.digit    = aip_pkg::BASE_W'(req_ch - aip_pkg::CH_LOWER_A +
                                         aip_pkg::ALPHA_DIGIT_OFS);
      end else if (req_ch inside {[aip_pkg::CH_UPPER_A:aip_pkg::CH_UPPER_Z]}) begin
         cls.is_alnum = 1'b1;
         cls.digit    = aip_pkg::BASE_W'(req_ch - aip_pkg::CH_UPPER_A +
                                         aip_pkg::ALPHA_DIGIT_OFS);
      end
   end

   assign q_push       = req_push && !q_full;
   assign cmd.cls      = cls;
   assign cmd.base_sel = base_sel;

endmodule

>>> sv/aip_back.sv
// Back stage: parse sequencer with the multiply-add accumulator.
`include "ascii_integer_parser_defines.svh"

module aip_back #(
   parameter int COUNT_LIMIT = aip_pkg::COUNT_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  aip_pkg::cmd_type     cmd,
   output logic                 cmd_pop,
   input  logic                 res_full,
   output logic                 res_push,
   output aip_pkg::result_type  res
);

   localparam int LIM_W = $clog2(COUNT_LIMIT + 1);
   localparam int CW    = (LIM_W > aip_pkg::OFF_W) ? LIM_W : aip_pkg::OFF_W;
   localparam int VW    = aip_pkg::VALUE_W;
   localparam int BW    = aip_pkg::BASE_W;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [VW-1:0]    acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [BW-1:0]    base_ff, base_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic             fire, take, emit, signed_entry, digit_step;
   logic [BW-1:0]    step_base;
   logic [VW-1:0]    product;

   assign fire    = cmd_valid && !res_full;
   assign cmd_pop = fire;
   assign product = acc_ff * {{(VW - BW){1'b0}}, step_base};

   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      take         = 1'b0;
      emit         = 1'b0;
      signed_entry = 1'b0;
      digit_step   = 1'b0;
      step_base    = base_ff;

      case (phase_ff)
         PH_SPACE: begin
            if (cmd.cls.is_space) begin
               take = 1'b1;
            end else if (cmd.cls.is_sign) begin
               take     = 1'b1;
               neg_in   = cmd.cls.is_minus;
               phase_in = PH_SIGNED;
            end else begin
               signed_entry = 1'b1;
            end
         end
         PH_SIGNED: begin
            signed_entry = 1'b1;
         end
         PH_ZERO: begin
            if (cmd.cls.is_x) begin
               take     = 1'b1;
               base_in  = aip_pkg::BASE_HEX;
               phase_in = PH_DIGITS;
            end else begin
               digit_step = 1'b1;
            end
         end
         default: begin
            digit_step = 1'b1;
         end
      endcase

      // The base is latched from the first character after whitespace and sign.
      if (signed_entry) begin
         if (cmd.base_sel == aip_pkg::BASE_AUTO) begin
            if (cmd.cls.is_zero) begin
               take     = 1'b1;
               base_in  = aip_pkg::BASE_OCT;
               phase_in = PH_ZERO;
            end else begin
               step_base  = aip_pkg::BASE_DEC;
               digit_step = 1'b1;
            end
         end else if (cmd.base_sel == aip_pkg::BASE_HEX && cmd.cls.is_zero) begin
            take     = 1'b1;
            base_in  = aip_pkg::BASE_HEX;
            phase_in = PH_ZERO;
         end else begin
            step_base  = cmd.base_sel;
            digit_step = 1'b1;
         end
      end

      if (digit_step) begin
         if (cmd.cls.is_alnum && (cmd.cls.digit < step_base)) begin
            take     = 1'b1;
            acc_in   = product + {{(VW - BW){1'b0}}, cmd.cls.digit};
            base_in  = step_base;
            phase_in = PH_DIGITS;
         end else begin
            emit = 1'b1;
         end
      end

      if (take && (cnt_ff < CW'(COUNT_LIMIT))) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (emit) begin
         phase_in = PH_SPACE;
         acc_in   = '0;
         neg_in   = 1'b0;
         base_in  = '0;
         cnt_in   = '0;
      end
   end

   assign res_push       = fire && emit;
   assign res.value      = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign res.end_offset = cnt_ff[aip_pkg::OFF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         cnt_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         cnt_ff   <= cnt_in;
      end
   end

   `AIP_ASSERT_NEXT(a_emit_clears, res_push, phase_ff == PH_SPACE && cnt_ff == '0, "parse not cleared")
   `AIP_ASSERT_IMPL(a_cnt_limit, 1'b1, cnt_ff <= CW'(COUNT_LIMIT), "count beyond limit")
   `AIP_ASSERT_IMPL(a_space_idle, phase_ff == PH_SPACE, acc_ff == '0 && base_ff == '0, "stale parse state")

endmodule

>>> sv/ascii_integer_parser.sv
// A stopping character taken by the back stage writes its result into the result queue, which feeds the rsp ports.
// Throughput: one character per cycle while the result queue has room; the back stage uses a 32x6 multiply-add.
// A full result queue stalls the back stage, and the character queue then raises req_full.
// Reset (synchronous, active high) empties both queues, restarts the parse and sets base 10.
// No clearing pass: the block takes characters from the first cycle after reset.
module ascii_integer_parser #(
   parameter int COUNT_LIMIT = aip_pkg::COUNT_LIMIT_DEF,
   parameter int QUEUE_DEPTH = aip_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Character request channel.
   input  logic                          req_push,
   input  logic [aip_pkg::CH_W-1:0]      req_ch,
   output logic                          req_full,
   // Result request channel.
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [aip_pkg::VALUE_W-1:0] rsp_value,
   output logic [aip_pkg::OFF_W-1:0]     rsp_end_offset,
   // Configuration port.
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [aip_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [aip_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [aip_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int CMD_W = $bits(aip_pkg::cmd_type);
   localparam int RES_W = $bits(aip_pkg::result_type);

   // The only register is base_select; its index is taken from the word address bit.
   logic [aip_pkg::BASE_W-1:0] base_sel_ff;
   logic                       csr_write;
   logic                       csr_hit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = (csr_paddr[2] == aip_pkg::REG_BASE_SELECT);

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = {{(aip_pkg::DATA_W - aip_pkg::BASE_W){1'b0}}, base_sel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_sel_ff <= aip_pkg::BASE_RESET;
      end else if (csr_write && csr_hit) begin
         base_sel_ff <= csr_pwdata[aip_pkg::BASE_W-1:0];
      end
   end

   // The front stage classifies each request and tags it with the base setting in force,
   // so the back stage never looks at the register directly.
   aip_pkg::cmd_type    front_cmd, back_cmd;
   logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic [CMD_W-1:0]    cmd_dout;

   aip_front u_front (
      .req_push (req_push),
      .req_ch   (req_ch),
      .base_sel (base_sel_ff),
      .q_full   (cmd_full),
      .q_push   (cmd_push),
      .cmd      (front_cmd)
   );

   assign req_full = cmd_full;

   aip_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (front_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .dout  (cmd_dout)
   );

   assign back_cmd = cmd_dout;

   // The back stage runs the parse; it advances only when the result queue has room.
   aip_pkg::result_type back_res, rsp_res;
   logic                res_push, res_full;
   logic [RES_W-1:0]    res_dout;

   aip_back #(
      .COUNT_LIMIT (COUNT_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (back_cmd),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (back_res)
   );

   // The result queue separates the parse from the consumer of results.
   aip_fifo #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (back_res),
      .full  (res_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (res_dout)
   );

   assign rsp_res        = res_dout;
   assign rsp_value      = $signed(rsp_res.value);
   assign rsp_end_offset = rsp_res.end_offset;

endmodule
